// File: src/npc_pkg.sv
// Package for the nearest palette color search: constants, weights and types.
// No dependencies; imported by every module of the block.
`default_nettype none
package npc_pkg;
    localparam int unsigned PALETTE_ENTRIES_DEF = 256;
    localparam int unsigned COMP_W = 8;
    localparam int unsigned MAG_W = 17;
    localparam int unsigned SQ_W = 18;   // r^2+g^2+b^2 <= 195075
    localparam int unsigned RAD_W = 34;  // radicand = sum << 16
    localparam int unsigned DIST_W = 50;
    localparam int unsigned CMD_W = 1;

    localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

    localparam logic [15:0] W_RED   = 16'd19661;
    localparam logic [15:0] W_GREEN = 16'd38666;
    localparam logic [15:0] W_BLUE  = 16'd7209;
    localparam logic [15:0] W_MAG   = 16'd15292;

    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } sqrt_ctl_t;
endpackage
`default_nettype wire

// File: src/nearest_palette_color.sv
// Top level of the nearest palette color search.
// Depends on npc_pkg, npc_sqrt and npc_dist.
//
// Usage: drive cmd, entry_index, red, green, blue and pulse start while busy
// is low; the beat is taken at that edge. cmd = CMD_WRITE stores one palette
// entry and its magnitude; cmd = CMD_QUERY searches the palette.
// A write runs the square root of the entry (17 steps), then the store
// write; an entry_index beyond the palette is dropped and gives no result.
// A query first takes the query magnitude from the shared bit-serial root
// unit, then streams one entry a cycle from the palette memory read port
// through the four-stage distance pipeline, and ends with a final compare.
// The result beat shows on nearest_index with valid high for exactly one
// cycle; the receiver cannot stall it.
// Reset clears the control state and the per-entry valid bits; an entry not
// written since reset reads as black with magnitude zero. Ties keep the
// lowest index.
`default_nettype none
module nearest_palette_color
    import npc_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [7:0]        entry_index,
    input  wire logic [COMP_W-1:0] red,
    input  wire logic [COMP_W-1:0] green,
    input  wire logic [COMP_W-1:0] blue,
    output logic                   valid,
    output logic [7:0]             nearest_index
);
    localparam int unsigned IDX_W = $clog2(PALETTE_ENTRIES);
    localparam int unsigned CNT_W = IDX_W + 1;
    localparam int unsigned LAT = 5; // read + 4 pipe stages

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROOT = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [7:0]        widx_reg;
    logic [COMP_W-1:0] r_reg, g_reg, b_reg;
    logic [MAG_W-1:0]  qm_reg;
    logic [CNT_W-1:0]  rd_cnt_reg, rd_cnt_next;
    logic [CNT_W-1:0]  cmp_cnt_reg;
    logic [LAT-1:0]    vpipe_reg;
    logic [DIST_W-1:0] best_dist_reg;
    logic [IDX_W-1:0]  best_reg;
    logic              valid_reg;

    logic [23:0]       pal_mem [PALETTE_ENTRIES];
    logic [MAG_W-1:0]  mag_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] ok_reg;
    logic [23:0]       pal_q_reg;
    logic [MAG_W-1:0]  mag_q_reg;
    logic              ok_q_reg;

    logic [SQ_W-1:0]   sq_sum;
    logic [RAD_W-1:0]  radicand;
    sqrt_ctl_t         sctl;
    logic [MAG_W-1:0]  root;
    logic [DIST_W-1:0] distance;
    logic              accept;
    logic              wr_en;
    logic              last_rd;
    logic [COMP_W-1:0] er, eg, eb;
    logic [MAG_W-1:0]  em;

    assign accept = start && state_reg == ST_IDLE;
    assign busy   = state_reg != ST_IDLE;
    assign sq_sum = SQ_W'(red) * SQ_W'(red) + SQ_W'(green) * SQ_W'(green)
                    + SQ_W'(blue) * SQ_W'(blue);
    assign radicand = {sq_sum, 16'd0};

    npc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept),
        .radicand (radicand),
        .ctl      (sctl),
        .root     (root)
    );

    // writes land once the entry magnitude is ready
    assign wr_en = sctl.done && cmd_reg == CMD_WRITE
                   && 32'(widx_reg) < PALETTE_ENTRIES;
    assign last_rd = rd_cnt_reg == CNT_W'(PALETTE_ENTRIES - 1);

    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (sctl.done)
                begin
                    rd_cnt_next = '0;
                    state_next  = (cmd_reg == CMD_QUERY) ? ST_SCAN : ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (!last_rd && !vpipe_reg[0] && rd_cnt_reg != '0
                    && vpipe_reg == '0)
                    state_next = ST_IDLE;
                else if (rd_cnt_reg != CNT_W'(PALETTE_ENTRIES))
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                else if (vpipe_reg == '0)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_cnt_reg  <= '0;
            cmp_cnt_reg <= '0;
            vpipe_reg   <= '0;
            valid_reg   <= 1'b0;
            ok_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            vpipe_reg  <= {vpipe_reg[LAT-2:0],
                           state_reg == ST_SCAN && rd_cnt_reg != CNT_W'(PALETTE_ENTRIES)};
            valid_reg  <= 1'b0;
            if (wr_en)
                ok_reg[IDX_W'(widx_reg)] <= 1'b1;
            if (state_reg == ST_ROOT && sctl.done)
                cmp_cnt_reg <= '0;
            else if (vpipe_reg[LAT-1])
            begin
                cmp_cnt_reg <= cmp_cnt_reg + 1'b1;
                if (cmp_cnt_reg == CNT_W'(PALETTE_ENTRIES - 1))
                    valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            widx_reg <= entry_index;
            r_reg    <= red;
            g_reg    <= green;
            b_reg    <= blue;
        end
        if (sctl.done)
            qm_reg <= root;
        if (wr_en)
        begin
            pal_mem[IDX_W'(widx_reg)] <= {r_reg, g_reg, b_reg};
            mag_mem[IDX_W'(widx_reg)] <= root;
        end
        pal_q_reg <= pal_mem[rd_cnt_reg[IDX_W-1:0]];
        mag_q_reg <= mag_mem[rd_cnt_reg[IDX_W-1:0]];
        ok_q_reg  <= ok_reg[rd_cnt_reg[IDX_W-1:0]];
        // strictly smaller wins; first entry seeds the best
        if (vpipe_reg[LAT-1] && (cmp_cnt_reg == '0 || distance < best_dist_reg))
        begin
            best_dist_reg <= distance;
            best_reg      <= cmp_cnt_reg[IDX_W-1:0];
        end
    end

    // entries never written read as black
    assign er = ok_q_reg ? pal_q_reg[23:16] : '0;
    assign eg = ok_q_reg ? pal_q_reg[15:8]  : '0;
    assign eb = ok_q_reg ? pal_q_reg[7:0]   : '0;
    assign em = ok_q_reg ? mag_q_reg        : '0;

    npc_dist u_dist (
        .clk      (clk),
        .pr       (er),
        .pg       (eg),
        .pb       (eb),
        .pm       (em),
        .qr       (r_reg),
        .qg       (g_reg),
        .qb       (b_reg),
        .qm       (qm_reg),
        .distance (distance)
    );

    assign valid         = valid_reg;
    assign nearest_index = 8'(best_reg);

    a_idle_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |=> !busy)
        else $error("busy after result");
    a_root_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sctl.busy |-> state_reg == ST_ROOT)
        else $error("root unit running outside root phase");
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN |-> !wr_en)
        else $error("palette write during scan");
endmodule
`default_nettype wire

// File: src/npc_sqrt.sv
// Bit-serial integer square root: one result bit per cycle.
// Depends on npc_pkg.
`default_nettype none
module npc_sqrt
    import npc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [RAD_W-1:0] radicand,
    output sqrt_ctl_t             ctl,
    output logic      [MAG_W-1:0] root
);
    localparam int unsigned STEPS = RAD_W / 2;
    localparam int unsigned CNT_W = $clog2(STEPS + 1);

    logic [RAD_W-1:0] rem_reg, rem_next;
    logic [RAD_W-1:0] val_reg, val_next;
    logic [MAG_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [MAG_W+1:0] trial;
    logic [MAG_W+1:0] win;

    always_comb
    begin
        rem_next  = rem_reg;
        val_next  = val_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        win   = {rem_reg[MAG_W-1:0], val_reg[RAD_W-1 -: 2]};
        trial = {root_reg, 2'b01};
        if (start)
        begin
            rem_next  = '0;
            val_next  = radicand;
            root_next = '0;
            cnt_next  = CNT_W'(STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // restoring step on the next two radicand bits
            val_next = {val_reg[RAD_W-3:0], 2'b00};
            if (win >= trial)
            begin
                rem_next  = RAD_W'(win - trial);
                root_next = {root_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = RAD_W'(win);
                root_next = {root_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        val_reg  <= val_next;
        root_reg <= root_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign root      = root_reg;
endmodule
`default_nettype wire

// File: src/npc_dist.sv
// Pipelined weighted distance unit: one palette entry enters per cycle.
// Depends on npc_pkg.
`default_nettype none
module npc_dist
    import npc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic [COMP_W-1:0] pr,
    input  wire logic [COMP_W-1:0] pg,
    input  wire logic [COMP_W-1:0] pb,
    input  wire logic [MAG_W-1:0]  pm,
    input  wire logic [COMP_W-1:0] qr,
    input  wire logic [COMP_W-1:0] qg,
    input  wire logic [COMP_W-1:0] qb,
    input  wire logic [MAG_W-1:0]  qm,
    output logic      [DIST_W-1:0] distance
);
    logic [COMP_W-1:0] dr_reg, dg_reg, db_reg;
    logic [MAG_W-1:0]  dm_reg;
    logic [15:0]       sr_reg, sg_reg, sb_reg;
    logic [33:0]       sm_reg;
    logic [31:0]       tr_reg, tg_reg, tb_reg;
    logic [DIST_W-1:0] tm_reg;
    logic [DIST_W-1:0] dist_reg;

    always_ff @(posedge clk)
    begin
        // stage 1: absolute differences
        dr_reg <= (pr >= qr) ? pr - qr : qr - pr;
        dg_reg <= (pg >= qg) ? pg - qg : qg - pg;
        db_reg <= (pb >= qb) ? pb - qb : qb - pb;
        dm_reg <= (pm >= qm) ? pm - qm : qm - pm;
        // stage 2: squares
        sr_reg <= 16'(dr_reg) * 16'(dr_reg);
        sg_reg <= 16'(dg_reg) * 16'(dg_reg);
        sb_reg <= 16'(db_reg) * 16'(db_reg);
        sm_reg <= 34'(dm_reg) * 34'(dm_reg);
        // stage 3: weights
        tr_reg <= 32'(sr_reg) * 32'(W_RED);
        tg_reg <= 32'(sg_reg) * 32'(W_GREEN);
        tb_reg <= 32'(sb_reg) * 32'(W_BLUE);
        tm_reg <= DIST_W'(sm_reg) * DIST_W'(W_MAG);
        // stage 4: sum at 2^32 scale
        dist_reg <= ((DIST_W'(tr_reg) + DIST_W'(tg_reg) + DIST_W'(tb_reg)) << 16) + tm_reg;
    end

    assign distance = dist_reg;
endmodule
`default_nettype wire

// File: tb/nearest_palette_color_checker.sv
// Checker for the nearest palette color search: watches accepted beats,
// predicts the nearest index from its own palette copy and compares results.
// Depends on npc_pkg.
`default_nettype none
module nearest_palette_color_checker
    import npc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [7:0]        entry_index,
    input  wire logic [COMP_W-1:0] red,
    input  wire logic [COMP_W-1:0] green,
    input  wire logic [COMP_W-1:0] blue,
    input  wire logic              valid,
    input  wire logic [7:0]        nearest_index,
    output int                     errors,
    output int                     pending
);
    logic [23:0]      pal_color [256];
    logic [MAG_W-1:0] pal_mag [256];
    logic [7:0]       nearest_q[$];

    function automatic logic [MAG_W-1:0] color_magnitude(logic [7:0] r, logic [7:0] g,
                                                         logic [7:0] b);
        logic [RAD_W-1:0] rad;
        logic [RAD_W-1:0] root;
        logic [RAD_W-1:0] trial;
        rad = ({26'd0, r} * r + {26'd0, g} * g + {26'd0, b} * b) << 16;
        root = '0;
        // bit-serial root by trial squaring, one root bit per step
        for (int k = 16; k >= 0; k--)
        begin
            trial = root | (RAD_W'(1) << k);
            if (trial * trial <= rad)
                root = trial;
        end
        return root[MAG_W-1:0];
    endfunction

    function automatic logic [7:0] nearest_entry(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [MAG_W-1:0] mq;
        logic [63:0]      distance;
        logic [63:0]      best_dist;
        logic [63:0]      dr, dg, db, dv;
        logic [7:0]       best;
        mq = color_magnitude(r, g, b);
        best = '0;
        best_dist = '0;
        for (int i = 0; i < 256; i++)
        begin
            dr = (pal_color[i][23:16] >= r) ? pal_color[i][23:16] - r : r - pal_color[i][23:16];
            dg = (pal_color[i][15:8] >= g) ? pal_color[i][15:8] - g : g - pal_color[i][15:8];
            db = (pal_color[i][7:0] >= b) ? pal_color[i][7:0] - b : b - pal_color[i][7:0];
            dv = (pal_mag[i] >= mq) ? pal_mag[i] - mq : mq - pal_mag[i];
            distance = ((W_RED * dr * dr + W_GREEN * dg * dg + W_BLUE * db * db) << 16)
                     + W_MAG * dv * dv;
            // strictly smaller only: lowest index keeps ties
            if (i == 0 || distance < best_dist)
            begin
                best_dist = distance;
                best = i[7:0];
            end
        end
        return best;
    endfunction

    task automatic report_mismatch(string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    initial
    begin
        errors = 0;
        for (int i = 0; i < 256; i++)
        begin
            pal_color[i] = '0;
            pal_mag[i] = '0;
        end
    end

    assign pending = nearest_q.size();

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (valid)
            begin
                if (nearest_q.size() == 0)
                    report_mismatch($sformatf("unexpected result %0d", nearest_index));
                else if (nearest_q[0] !== nearest_index)
                begin
                    report_mismatch($sformatf("nearest_index %0d, want %0d",
                                              nearest_index, nearest_q[0]));
                    void'(nearest_q.pop_front());
                end
                else
                    void'(nearest_q.pop_front());
            end
            if (start && !busy)
            begin
                if (cmd == CMD_WRITE)
                begin
                    pal_color[entry_index] = {red, green, blue};
                    pal_mag[entry_index] = color_magnitude(red, green, blue);
                end
                else
                    nearest_q.push_back(nearest_entry(red, green, blue));
            end
        end
    end
endmodule
`default_nettype wire

// File: tb/nearest_palette_color_test.sv
// Top of the nearest palette color testbench: clock, reset, stimulus, verdict.
// Depends on npc_pkg, nearest_palette_color and nearest_palette_color_checker.
`default_nettype none
module nearest_palette_color_test;
    import npc_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [CMD_W-1:0]  cmd;
    logic [7:0]        entry_index;
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              valid;
    logic [7:0]        nearest_index;
    int                errors;
    int                pending;
    bit                no_idle;

    nearest_palette_color u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .entry_index(entry_index), .red(red), .green(green), .blue(blue),
        .valid(valid), .nearest_index(nearest_index)
    );

    nearest_palette_color_checker u_check (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .entry_index(entry_index), .red(red), .green(green), .blue(blue),
        .valid(valid), .nearest_index(nearest_index),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Drive one beat: optionally idle first, then hold start until accepted.
    // Start stays high afterwards; the next idle cycle or the caller drops it.
    task automatic send_beat(logic [CMD_W-1:0] c, logic [7:0] idx,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while (!no_idle && $urandom_range(99) < 23)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd <= c;
        entry_index <= idx;
        red <= r;
        green <= g;
        blue <= b;
        // the beat is taken at the edge where busy is low
        do
            @(posedge clk);
        while (busy);
    endtask

    // Random component level that often sits on an extreme.
    function automatic logic [7:0] pick_level();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    initial
    begin
        start = 1'b0;
        cmd = CMD_WRITE;
        entry_index = '0;
        red = '0;
        green = '0;
        blue = '0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: query the all-black palette, so every entry ties and index 0 wins.
        send_beat(CMD_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
        send_beat(CMD_QUERY, 8'd77, 8'd0, 8'd0, 8'd0);
        // Fill the extremes of the index range and the color corners.
        send_beat(CMD_WRITE, 8'd255, 8'd255, 8'd255, 8'd255);
        send_beat(CMD_WRITE, 8'd0, 8'd255, 8'd0, 8'd0);
        send_beat(CMD_WRITE, 8'd1, 8'd0, 8'd255, 8'd0);
        send_beat(CMD_WRITE, 8'd2, 8'd0, 8'd0, 8'd255);
        send_beat(CMD_QUERY, 8'd0, 8'd255, 8'd255, 8'd255);
        send_beat(CMD_QUERY, 8'd0, 8'd250, 8'd5, 8'd5);
        send_beat(CMD_QUERY, 8'd0, 8'd0, 8'd250, 8'd0);
        send_beat(CMD_QUERY, 8'd0, 8'd0, 8'd0, 8'd250);
        send_beat(CMD_QUERY, 8'd0, 8'd0, 8'd0, 8'd0);
        // Duplicate a color at a higher index: the lower index must keep the tie.
        send_beat(CMD_WRITE, 8'd200, 8'd0, 8'd255, 8'd0);
        send_beat(CMD_QUERY, 8'd0, 8'd0, 8'd255, 8'd0);
        send_beat(CMD_WRITE, 8'd1, 8'd170, 8'd85, 8'd170);
        send_beat(CMD_QUERY, 8'd255, 8'd170, 8'd85, 8'd170);
        send_beat(CMD_QUERY, 8'd0, 8'd0, 8'd255, 8'd0);

        // Random: mostly writes early to build a varied palette, then a mix.
        for (int n = 0; n < 1800; n++)
        begin
            no_idle = (n >= 600 && n < 800);
            if ($urandom_range(99) < ((n < 300) ? 85 : 40))
                send_beat(CMD_WRITE, 8'($urandom), pick_level(), pick_level(),
                          pick_level());
            else
                send_beat(CMD_QUERY, 8'($urandom), pick_level(), pick_level(),
                          pick_level());
        end
        start <= 1'b0;

        // Drain: wait for every expected result, then for the block to settle.
        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: allows roughly 1800 beats, each up to a full query, several times over.
    initial
    begin
        #20000000;
        $display("FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
src/npc_pkg.sv
src/npc_sqrt.sv
src/npc_dist.sv
src/nearest_palette_color.sv
tb/nearest_palette_color_checker.sv
tb/nearest_palette_color_test.sv
